### hw/rtl/smm_pkg.sv
// shared constants and types for the sliding window median filter
package smm_pkg;

	localparam int WinMax  = 64;
	localparam int SampleW = 32;
	localparam int WsW     = 7;
	localparam int CntW    = $clog2(WinMax + 1);
	localparam int IdxW    = (WinMax > 1) ? $clog2(WinMax) : 1;

	// control from the window bookkeeping to the sorted cell row
	typedef struct packed {
		logic            upd;
		logic            full;
		logic [CntW-1:0] k;
		logic [IdxW-1:0] cnt;
		logic [IdxW-1:0] evict_age;
		logic [IdxW-1:0] mid;
	} smm_ctrl_t;

endpackage

### hw/rtl/smm_if.sv
// valid/ready stream interfaces for samples and medians
interface smm_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [smm_pkg::SampleW-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface smm_median_if;
	logic                                valid;
	logic                                ready;
	logic signed [smm_pkg::SampleW-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

### hw/rtl/sliding_window_median.sv
// top level of the sliding window lower-median filter
// Running lower-median filter over a window of K signed 32-bit samples, K set by
// window_size (zero acts as one, values above 64 act as 64). The window lives in a
// row of 64 sorted cells, each holding a sample and its age; one input transfer per
// clock is sustained while the output is not stalled, since each sample is registered,
// then the oldest cell is dropped and the new sample is inserted by a parallel
// compare-and-shift across the row, and the cell at rank (K-1)/2 is then registered
// as the result. The first
// K-1 samples after reset or after a window_size write give no result; every later
// sample gives one. Writing window_size empties the window; write it only while
// the block is idle. There are no memories and no clearing pass after reset.
module sliding_window_median (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [smm_pkg::WsW-1:0]   cfg_wdata,
	smm_sample_if.sink                din,
	smm_median_if.source              dout
);
	import smm_pkg::*;

	// configuration and window bookkeeping
	logic [WsW-1:0]            ws_q;
	logic [CntW-1:0]           fill_q;
	logic [CntW-1:0]           k_eff;
	logic                      full;
	logic                      emit;

	// input stage, pending median read, result register
	logic                      valid_s1;
	logic signed [SampleW-1:0] sample_s1;
	logic                      rd_s2;
	logic                      out_valid_q;
	logic signed [SampleW-1:0] median_q;

	logic                      out_free;
	logic                      s2_go;
	logic                      s2_free;
	logic                      s1_fire;

	smm_ctrl_t                 ctrl;
	logic signed [SampleW-1:0] cell_med;

	// effective window length: zero means one, clamp to the cell count
	always_comb begin
		if (ws_q == '0) begin
			k_eff = CntW'(1);
		end else if (int'(ws_q) > WinMax) begin
			k_eff = CntW'(WinMax);
		end else begin
			k_eff = CntW'(ws_q);
		end
	end

	assign full = (fill_q == k_eff);
	// a full window always emits, a filling one emits when it just becomes full
	assign emit = full || ((fill_q + 1'b1) == k_eff);

	// back-pressure chain: result register, then median read, then cell update
	assign out_free = !out_valid_q || dout.ready;
	assign s2_go    = rd_s2 && out_free;
	assign s2_free  = !rd_s2 || out_free;
	assign s1_fire  = valid_s1 && s2_free;
	assign din.ready = !valid_s1 || s1_fire;

	// control bundle for the cell row
	always_comb begin
		ctrl.upd       = s1_fire;
		ctrl.full      = full;
		ctrl.k         = k_eff;
		ctrl.cnt       = full ? IdxW'(k_eff - 1'b1) : IdxW'(fill_q);
		ctrl.evict_age = IdxW'(k_eff - 1'b1);
		ctrl.mid       = IdxW'((k_eff - 1'b1) >> 1);
	end

	smm_cells u_cells (
		.clk  (clk),
		.ctrl (ctrl),
		.key  (sample_s1),
		.med  (cell_med)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WsW'(1);
			fill_q      <= '0;
			valid_s1    <= 1'b0;
			rd_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q   <= cfg_wdata;
				fill_q <= '0;
			end else if (s1_fire && !full) begin
				fill_q <= fill_q + 1'b1;
			end

			if (din.ready) begin
				valid_s1 <= din.valid;
			end

			// a pending read is set by an emitting update, cleared once captured
			if (s1_fire) begin
				rd_s2 <= emit;
			end else if (s2_go) begin
				rd_s2 <= 1'b0;
			end

			if (out_free) begin
				out_valid_q <= s2_go;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			sample_s1 <= din.sample;
		end
		if (s2_go) begin
			median_q <= cell_med;
		end
	end

	assign dout.valid  = out_valid_q;
	assign dout.median = median_q;

	// the fill count never passes the window length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> (fill_q <= k_eff))
		else $error("fill count exceeds window length");

	// an update on a full window always leaves a median to read
	a_full_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && full) |=> rd_s2)
		else $error("full window update produced no median");

	// a captured median shows up at the output
	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go |=> out_valid_q)
		else $error("median read lost before the output register");

endmodule

### hw/rtl/smm_cells.sv
// sorted cell row with age tags: evict oldest, insert new sample, pick median
module smm_cells (
	input  logic                              clk,
	input  smm_pkg::smm_ctrl_t                ctrl,
	input  logic signed [smm_pkg::SampleW-1:0] key,
	output logic signed [smm_pkg::SampleW-1:0] med
);
	import smm_pkg::*;

	logic signed [SampleW-1:0] val_q [WinMax];
	logic [IdxW-1:0]           age_q [WinMax];

	logic [WinMax-1:0]         ev;
	logic [WinMax-1:0]         gone;
	logic [WinMax-1:0]         lt;
	logic signed [SampleW-1:0] r_val [WinMax];
	logic [IdxW-1:0]           r_age [WinMax];
	logic signed [SampleW-1:0] n_val [WinMax];
	logic [IdxW-1:0]           n_age [WinMax];

	// oldest entry of a full window, then close the gap above it
	always_comb begin
		for (int i = 0; i < WinMax; i++) begin
			ev[i] = ctrl.full && (CntW'(i) < ctrl.k) && (age_q[i] == ctrl.evict_age);
		end
		for (int i = 0; i < WinMax; i++) begin
			gone[i] = |(ev & ({WinMax{1'b1}} >> (WinMax - 1 - i)));
		end
		for (int i = 0; i < WinMax - 1; i++) begin
			r_val[i] = gone[i] ? val_q[i + 1] : val_q[i];
			r_age[i] = gone[i] ? age_q[i + 1] : age_q[i];
		end
		r_val[WinMax-1] = val_q[WinMax-1];
		r_age[WinMax-1] = age_q[WinMax-1];
	end

	// insertion: cells at or below the key stay, the first above takes it, the rest shift up
	always_comb begin
		for (int i = 0; i < WinMax; i++) begin
			lt[i] = (CntW'(i) < CntW'(ctrl.cnt)) && (r_val[i] <= key);
		end
		n_val[0] = lt[0] ? r_val[0] : key;
		n_age[0] = lt[0] ? r_age[0] + 1'b1 : '0;
		for (int i = 1; i < WinMax; i++) begin
			if (lt[i]) begin
				n_val[i] = r_val[i];
				n_age[i] = r_age[i] + 1'b1;
			end else if (lt[i-1]) begin
				n_val[i] = key;
				n_age[i] = '0;
			end else begin
				n_val[i] = r_val[i-1];
				n_age[i] = r_age[i-1] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			for (int i = 0; i < WinMax; i++) begin
				val_q[i] <= n_val[i];
				age_q[i] <= n_age[i];
			end
		end
	end

	assign med = val_q[ctrl.mid];

endmodule

### sim/sliding_window_median_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the sliding window lower-median filter
module sliding_window_median_tb;

	import smm_pkg::*;

	localparam logic signed [SampleW-1:0] SampleMin = 32'sh8000_0000;
	localparam logic signed [SampleW-1:0] SampleMax = 32'sh7fff_ffff;
	localparam int RandomPhases = 12;
	localparam int PhaseItems   = 85;

	// receiver stall patterns
	typedef enum int {
		RxAlways,
		RxCoinFlip,
		RxPeriodic,
		RxLongStall
	} rx_pattern_e;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [WsW-1:0] cfg_wdata;

	smm_sample_if sample_ch ();
	smm_median_if median_ch ();

	sliding_window_median u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.din       (sample_ch),
		.dout      (median_ch)
	);

	always #10 clk = ~clk;

	// predictor state: window in arrival order and in ascending order
	logic signed [SampleW-1:0] window_arrival[$];
	logic signed [SampleW-1:0] window_sorted[$];
	logic [WsW-1:0] window_size_reg;

	// medians still owed by the block, oldest first
	logic signed [SampleW-1:0] median_q[$];
	logic signed [SampleW-1:0] want_median;

	int error_count;
	int samples_sent;
	int medians_seen;
	int window_writes;

	// sender and receiver pacing
	bit tx_bursty;
	int burst_left;
	rx_pattern_e rx_pattern;
	int rx_tick;
	int stall_left;

	// zero acts as one, anything past the row length acts as the row length
	function automatic int unsigned window_len();
		int unsigned k;
		k = 32'(window_size_reg);
		if (k < 1) k = 1;
		if (k > WinMax) k = WinMax;
		return k;
	endfunction

	// advance the predicted window by one sample; has_median is set once it is full
	task automatic window_predict(input logic signed [SampleW-1:0] value,
			output bit has_median, output logic signed [SampleW-1:0] median);
		int unsigned k;
		int idx;
		logic signed [SampleW-1:0] oldest;
		k = window_len();
		has_median = 1'b0;
		median = '0;
		if (window_arrival.size() == k) begin
			oldest = window_arrival.pop_front();
			// any equal copy may go, the median value is the same
			idx = 0;
			while (window_sorted[idx] != oldest) idx++;
			window_sorted.delete(idx);
		end
		window_arrival.insert(window_arrival.size(), value);
		idx = 0;
		while (idx < window_sorted.size() && window_sorted[idx] <= value) idx++;
		window_sorted.insert(idx, value);
		if (window_arrival.size() == k) begin
			has_median = 1'b1;
			median = window_sorted[(k - 1) / 2];
		end
	endtask

	// mix of full-range values, clustered small values (many duplicates) and extremes
	function automatic logic signed [SampleW-1:0] rand_sample();
		int pick;
		int tmp;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			return $signed($urandom);
		end else if (pick < 8) begin
			tmp = $urandom_range(0, 8);
			return tmp - 4;
		end else begin
			case ($urandom_range(0, 3))
				0: return SampleMin;
				1: return SampleMax;
				2: return '0;
				default: return -1;
			endcase
		end
	endfunction

	// one sample transfer; predicts the median on acceptance
	task automatic send_sample(input logic signed [SampleW-1:0] value);
		int gap;
		bit has_median;
		logic signed [SampleW-1:0] median;
		if (tx_bursty && burst_left == 0) begin
			gap = $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				sample_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 20);
		end
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= value;
		// the transfer happens at the first rising edge with ready high
		do @(posedge clk); while (!sample_ch.ready);
		if (burst_left > 0) burst_left--;
		samples_sent++;
		window_predict(value, has_median, median);
		if (has_median) median_q.insert(median_q.size(), median);
	endtask

	// stop sending and let every owed median come out, plus the pipeline depth
	task automatic drain_block();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write while idle; it also empties the window
	task automatic write_window_size(input logic [WsW-1:0] wsize);
		drain_block();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= wsize;
		@(negedge clk);
		cfg_we <= 1'b0;
		window_size_reg = wsize;
		window_arrival.delete();
		window_sorted.delete();
		window_writes++;
	endtask

	// reset value of the window size is one: every sample is its own median
	task automatic test_reset_default();
		tx_bursty = 1'b1;
		rx_pattern = RxCoinFlip;
		send_sample(SampleMin);
		send_sample(SampleMax);
		send_sample('0);
		send_sample(-1);
		send_sample(1);
	endtask

	// small windows: zero size, even size, equal samples, refill after a write
	task automatic test_window_edges();
		write_window_size('0);
		send_sample(SampleMax);
		send_sample(SampleMin);
		send_sample(32'sh5555_aaaa);
		// even window takes the lower of the two middle values
		write_window_size(7'd2);
		send_sample(SampleMax);
		send_sample(SampleMin);
		send_sample(SampleMin);
		send_sample(SampleMax);
		// duplicates get evicted one copy at a time
		write_window_size(7'd3);
		send_sample(5);
		send_sample(5);
		send_sample(-5);
		send_sample(5);
		send_sample(-5);
		// partial window then a rewrite: the two held samples are dropped
		write_window_size(7'd3);
		send_sample(-7);
		send_sample(7);
		write_window_size(7'd3);
		send_sample(100);
		send_sample(-100);
		send_sample(0);
	endtask

	// random windows: full row, saturated sizes, zero, and many small sizes
	task automatic test_random_windows();
		logic [WsW-1:0] wsize;
		int phase;
		for (phase = 0; phase < RandomPhases; phase++) begin
			case (phase)
				0: wsize = 7'd64;
				1: wsize = 7'd127;
				2: wsize = 7'd65;
				3: wsize = 7'd1;
				4: wsize = 7'd0;
				5: wsize = 7'd2;
				default: begin
					if ($urandom_range(0, 2) == 0) wsize = WsW'($urandom_range(0, 127));
					else wsize = WsW'($urandom_range(3, 9));
				end
			endcase
			write_window_size(wsize);
			// first phase runs flat out on both sides
			if (phase == 0) begin
				tx_bursty = 1'b0;
				rx_pattern = RxAlways;
			end else begin
				tx_bursty = $urandom_range(0, 3) != 0;
				rx_pattern = rx_pattern_e'($urandom_range(0, 3));
			end
			burst_left = 0;
			repeat (PhaseItems) send_sample(rand_sample());
		end
	endtask

	// receiver stalls
	initial begin
		median_ch.ready = 1'b0;
		rx_tick = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			rx_tick++;
			case (rx_pattern)
				RxAlways: median_ch.ready <= 1'b1;
				RxCoinFlip: median_ch.ready <= 1'($urandom_range(0, 1));
				RxPeriodic: median_ch.ready <= (rx_tick % 5) != 3;
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						median_ch.ready <= 1'b0;
					end else if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(5, 20);
						median_ch.ready <= 1'b0;
					end else begin
						median_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// compare each median transfer against the oldest owed value
	always @(posedge clk) begin
		if (arst_n && median_ch.valid && median_ch.ready) begin
			medians_seen++;
			if (median_q.size() == 0) begin
				error_count++;
				$display("%0t: unexpected median, expected none, got %0d",
					$time, median_ch.median);
			end else begin
				want_median = median_q.pop_front();
				if (median_ch.median !== want_median) begin
					error_count++;
					$display("%0t: median mismatch, expected %0d, got %0d",
						$time, want_median, median_ch.median);
				end
			end
		end
	end

	// hard stop in case a handshake never completes
	initial begin
		#20_000_000;
		$display("%0t: timeout with %0d medians outstanding", $time, median_q.size());
		$display("sliding_window_median_tb: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		window_size_reg = 7'd1;
		error_count = 0;
		samples_sent = 0;
		medians_seen = 0;
		window_writes = 0;
		tx_bursty = 1'b0;
		burst_left = 0;
		rx_pattern = RxAlways;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_default();
		test_window_edges();
		test_random_windows();
		drain_block();
		repeat (10) @(posedge clk);

		if (median_q.size() != 0) begin
			error_count++;
			$display("%0t: %0d medians never arrived, next expected %0d, got none",
				$time, median_q.size(), median_q[0]);
		end
		$display("%0d samples streamed through %0d window size writes (0, 1, 2, 64, 65, 127 and",
			samples_sent, window_writes);
		$display("random), %0d medians compared, %0d errors", medians_seen, error_count);
		if (error_count == 0) begin
			$display("sliding_window_median_tb: PASS");
		end else begin
			$display("sliding_window_median_tb: FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/smm_pkg.sv
hw/rtl/smm_if.sv
hw/rtl/smm_cells.sv
hw/rtl/sliding_window_median.sv
sim/sliding_window_median_tb.sv
